[sv/fad_pkg.sv]
`default_nettype none
package fad_pkg;

   localparam int MaxCand   = 16;
   localparam int MaxFaces  = 4;
   localparam int CandIdxW  = $clog2(MaxCand);
   localparam int CandCntW  = $clog2(MaxCand + 1);
   localparam int FaceIdxW  = (MaxFaces > 1) ? $clog2(MaxFaces) : 1;
   localparam int FaceCntW  = $clog2(MaxFaces + 1);
   localparam int QueueDepth = 2;
   localparam int QueueIdxW  = $clog2(QueueDepth);

   localparam logic [3:0] CsrLogitThr   = 4'd0;
   localparam logic [3:0] CsrOverlapThr = 4'd1;
   localparam logic [3:0] CsrScreenW    = 4'd2;
   localparam logic [3:0] CsrScreenH    = 4'd3;

   // decoded candidate box in pixels
   typedef struct packed {
      logic [9:0]         x1;
      logic [9:0]         y1;
      logic [9:0]         x2;
      logic [9:0]         y2;
      logic signed [15:0] score;
   } box_type;

   // one classified item handed from front to back
   typedef struct packed {
      box_type box;
      logic    keep;
      logic    frame_end;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_NMS_CAND,
      ST_NMS_CHECK,
      ST_EMIT,
      ST_EMPTY
   } back_state_type;

endpackage
`default_nettype wire

[sv/fad_front.sv]
`default_nettype none
module fad_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [9:0]              anchor_id,
   input  wire logic signed [15:0]      score_logit,
   input  wire logic signed [15:0]      offset_x,
   input  wire logic signed [15:0]      offset_y,
   input  wire logic signed [15:0]      size_w,
   input  wire logic signed [15:0]      size_h,
   input  wire logic                    frame_end,
   input  wire logic signed [15:0]      logit_threshold,
   input  wire logic [9:0]              screen_width,
   input  wire logic [9:0]              screen_height,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output fad_pkg::work_type            out_work
);

   // stage 1: edges in 1/65536 screen units
   logic               s1_valid_ff;
   logic               s1_pass_ff;
   logic               s1_end_ff;
   logic signed [15:0] s1_score_ff;
   logic signed [18:0] s1_ex1_ff, s1_ex2_ff, s1_ey1_ff, s1_ey2_ff;
   logic signed [18:0] ex1_in, ex2_in, ey1_in, ey2_in;
   logic               out_valid_ff;
   fad_pkg::work_type  out_work_ff;
   fad_pkg::work_type  work_in;
   logic               s1_adv;
   logic               out_free;

   logic [9:0] local_idx;
   logic [8:0] cell_num;
   logic [3:0] col, row;
   logic       fine;
   logic signed [18:0] ax, ay;
   logic [16:0] cx, cy;

   // anchor centre from the index
   always_comb begin
      fine      = anchor_id >= 10'd512;
      local_idx = fine ? (anchor_id - 10'd512) : anchor_id;
      // divide by 6 via reciprocal multiply (local below 512 for the valid range)
      cell_num = fine ? 9'((({10'd0, local_idx} * 20'd683) >> 12))
                      : 9'(local_idx >> 1);
      if (fine) begin
         col = {1'b0, cell_num[2:0]};
         row = 4'(cell_num >> 3);
      end else begin
         col = cell_num[3:0];
         row = cell_num[7:4];
      end
      cx = fine ? (17'({col, 1'b1}) << 12) : (17'({col, 1'b1}) << 11);
      cy = fine ? (17'({row, 1'b1}) << 12) : (17'({row, 1'b1}) << 11);
      // rows past the grid: cell top bits still count
      if (fine)
         cy = 17'((({8'd0, cell_num} >> 3) * 2 + 1) << 12);
      ax = (19'(offset_x) <<< 1) + 19'(signed'({2'b0, cx}));
      ay = (19'(offset_y) <<< 1) + 19'(signed'({2'b0, cy}));
      ex1_in = ax - 19'(size_w);
      ex2_in = ax + 19'(size_w);
      ey1_in = ay - 19'(size_h);
      ey2_in = ay + 19'(size_h);
   end

   assign out_free = !out_valid_ff || out_ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign in_ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         s1_pass_ff  <= score_logit >= logit_threshold;
         s1_end_ff   <= frame_end;
         s1_score_ff <= score_logit;
         s1_ex1_ff   <= ex1_in;
         s1_ex2_ff   <= ex2_in;
         s1_ey1_ff   <= ey1_in;
         s1_ey2_ff   <= ey2_in;
      end
   end

   // pixel conversion with round and clamp
   function automatic logic [9:0] to_pixel(input logic signed [18:0] e,
                                           input logic [9:0] dim);
      logic signed [30:0] v;
      logic [14:0]        p;
      logic [9:0]         lim;
      begin
         v   = e * signed'({21'd0, dim}) + 31'sd32768;
         lim = (dim == 10'd0) ? 10'd0 : dim - 10'd1;
         p   = v[30:16];
         if (v < 0)
            to_pixel = 10'd0;
         else if (p > {5'd0, lim})
            to_pixel = lim;
         else
            to_pixel = p[9:0];
      end
   endfunction

   always_comb begin
      logic [9:0] px1, px2, py1, py2;
      logic       big;
      px1 = to_pixel(s1_ex1_ff, screen_width);
      px2 = to_pixel(s1_ex2_ff, screen_width);
      py1 = to_pixel(s1_ey1_ff, screen_height);
      py2 = to_pixel(s1_ey2_ff, screen_height);
      big = (11'(signed'({1'b0, px2})) - 11'(signed'({1'b0, px1})) >= 11'sd4) &&
            (11'(signed'({1'b0, py2})) - 11'(signed'({1'b0, py1})) >= 11'sd4);
      work_in.box.x1    = px1;
      work_in.box.y1    = py1;
      work_in.box.x2    = px2;
      work_in.box.y2    = py2;
      work_in.box.score = s1_score_ff;
      work_in.keep      = s1_pass_ff && big;
      work_in.frame_end = s1_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (s1_adv) begin
         out_work_ff <= work_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_work  = out_work_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_work))
      else $error("front output changed while stalled");
   a_s1: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("stage 1 item lost");

endmodule
`default_nettype wire

[sv/fad_queue.sv]
`default_nettype none
module fad_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fad_pkg::work_type in_work,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output fad_pkg::work_type      out_work
);

   fad_pkg::work_type mem_ff [fad_pkg::QueueDepth];
   logic [fad_pkg::QueueIdxW-1:0] wr_ff, rd_ff;
   logic [fad_pkg::QueueIdxW:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != (fad_pkg::QueueIdxW+1)'(fad_pkg::QueueDepth);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_work  = mem_ff[rd_ff];

   // pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (fad_pkg::QueueIdxW+1)'(push) - (fad_pkg::QueueIdxW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_work;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (fad_pkg::QueueIdxW+1)'(fad_pkg::QueueDepth))
      else $error("queue overfilled");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count mismatch");

endmodule
`default_nettype wire

[sv/fad_back.sv]
`default_nettype none
module fad_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fad_pkg::work_type in_work,
   input  wire logic [7:0]        overlap_threshold,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_face,
   output fad_pkg::box_type       rsp_box,
   output logic                   rsp_last
);

   fad_pkg::back_state_type state_ff, state_in;
   fad_pkg::box_type  store_ff [fad_pkg::MaxCand];
   logic [fad_pkg::CandCntW-1:0] count_ff, count_in;
   logic [fad_pkg::CandIdxW-1:0] slot_ff [fad_pkg::MaxFaces];
   logic [fad_pkg::FaceCntW-1:0] kept_ff, kept_in;
   logic [fad_pkg::CandCntW-1:0] ci_ff, ci_in;
   logic [fad_pkg::FaceCntW-1:0] kj_ff, kj_in;
   logic [fad_pkg::FaceCntW-1:0] ek_ff, ek_in;
   fad_pkg::work_type work_ff;
   fad_pkg::box_type  cand_ff, other_ff;
   logic              take, do_insert, add_slot, load_pair;

   // registered operands for the overlap test
   logic [9:0]  ix1, iy1, ix2, iy2;
   logic [10:0] iw, ih;
   logic [21:0] inter_ff, area_a_ff, area_b_ff;
   logic        pos_ff;
   logic [23:0] uni;
   logic [31:0] lhs, rhs;
   logic        suppress;

   always_comb begin
      ix1 = (cand_ff.x1 > other_ff.x1) ? cand_ff.x1 : other_ff.x1;
      iy1 = (cand_ff.y1 > other_ff.y1) ? cand_ff.y1 : other_ff.y1;
      ix2 = (cand_ff.x2 < other_ff.x2) ? cand_ff.x2 : other_ff.x2;
      iy2 = (cand_ff.y2 < other_ff.y2) ? cand_ff.y2 : other_ff.y2;
      iw  = {1'b0, ix2} - {1'b0, ix1};
      ih  = {1'b0, iy2} - {1'b0, iy1};
   end

   // overlap products, one stage after the operands load
   logic pair_load_ff;
   logic pair_ready_ff;
   always_ff @(posedge clock) begin
      pos_ff    <= (ix2 > ix1) && (iy2 > iy1);
      inter_ff  <= 22'(iw[9:0] * ih[9:0]);
      area_a_ff <= 22'((cand_ff.x2 - cand_ff.x1) * (cand_ff.y2 - cand_ff.y1));
      area_b_ff <= 22'((other_ff.x2 - other_ff.x1) * (other_ff.y2 - other_ff.y1));
   end

   always_comb begin
      uni      = 24'(area_a_ff) + 24'(area_b_ff) - 24'(inter_ff);
      lhs      = {2'b0, inter_ff, 8'd0};
      rhs      = 32'(uni) * 32'(overlap_threshold);
      suppress = pos_ff && (uni != 24'd0) && (lhs > rhs);
   end

   assign in_ready = state_ff == fad_pkg::ST_IDLE;
   assign take     = in_valid && in_ready;

   // next state and control
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      kept_in   = kept_ff;
      ci_in     = ci_ff;
      kj_in     = kj_ff;
      ek_in     = ek_ff;
      do_insert = 1'b0;
      add_slot  = 1'b0;
      load_pair = 1'b0;
      rsp_valid = 1'b0;
      rsp_face  = 1'b0;
      rsp_last  = 1'b0;
      rsp_box   = '0;
      case (state_ff)
         fad_pkg::ST_IDLE: begin
            if (take) state_in = fad_pkg::ST_INSERT;
         end
         fad_pkg::ST_INSERT: begin
            do_insert = work_ff.keep &&
               (count_ff < fad_pkg::CandCntW'(fad_pkg::MaxCand) ||
                work_ff.box.score > store_ff[fad_pkg::MaxCand-1].score);
            if (do_insert && count_ff < fad_pkg::CandCntW'(fad_pkg::MaxCand))
               count_in = count_ff + 1'b1;
            if (work_ff.frame_end) begin
               state_in = fad_pkg::ST_NMS_CAND;
               ci_in    = '0;
               kept_in  = '0;
            end else begin
               state_in = fad_pkg::ST_IDLE;
            end
         end
         fad_pkg::ST_NMS_CAND: begin
            if (ci_ff >= count_ff || kept_ff == fad_pkg::FaceCntW'(fad_pkg::MaxFaces)) begin
               ek_in    = '0;
               state_in = (kept_ff == '0) ? fad_pkg::ST_EMPTY : fad_pkg::ST_EMIT;
            end else if (kept_ff == '0) begin
               add_slot = 1'b1;
               kept_in  = kept_ff + 1'b1;
               ci_in    = ci_ff + 1'b1;
            end else begin
               kj_in     = '0;
               load_pair = 1'b1;
               state_in  = fad_pkg::ST_NMS_CHECK;
            end
         end
         fad_pkg::ST_NMS_CHECK: begin
            // wait until the pair's registered products are flagged by pair_ready_ff
            if (!pair_ready_ff) begin
               state_in = fad_pkg::ST_NMS_CHECK;
            end else if (suppress) begin
               ci_in    = ci_ff + 1'b1;
               state_in = fad_pkg::ST_NMS_CAND;
            end else if (kj_ff + 1'b1 == kept_ff) begin
               add_slot = 1'b1;
               kept_in  = kept_ff + 1'b1;
               ci_in    = ci_ff + 1'b1;
               state_in = fad_pkg::ST_NMS_CAND;
            end else begin
               kj_in     = kj_ff + 1'b1;
               load_pair = 1'b1;
            end
         end
         fad_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_face  = 1'b1;
            rsp_box   = store_ff[slot_ff[ek_ff[fad_pkg::FaceIdxW-1:0]]];
            rsp_last  = ek_ff + 1'b1 == kept_ff;
            if (rsp_ready) begin
               ek_in = ek_ff + 1'b1;
               if (rsp_last) begin
                  state_in = fad_pkg::ST_IDLE;
                  count_in = '0;
                  kept_in  = '0;
               end
            end
         end
         fad_pkg::ST_EMPTY: begin
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
            if (rsp_ready) begin
               state_in = fad_pkg::ST_IDLE;
               count_in = '0;
            end
         end
         default: state_in = fad_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fad_pkg::ST_IDLE;
         count_ff      <= '0;
         kept_ff       <= '0;
         pair_load_ff  <= 1'b0;
         pair_ready_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         kept_ff       <= kept_in;
         pair_load_ff  <= load_pair;
         pair_ready_ff <= pair_load_ff;
      end
      ci_ff <= ci_in;
      kj_ff <= kj_in;
      ek_ff <= ek_in;
      if (take) work_ff <= in_work;
      if (add_slot) slot_ff[kept_ff[fad_pkg::FaceIdxW-1:0]] <= ci_ff[fad_pkg::CandIdxW-1:0];
      if (load_pair) begin
         cand_ff  <= store_ff[ci_ff[fad_pkg::CandIdxW-1:0]];
         other_ff <= store_ff[slot_ff[kj_in[fad_pkg::FaceIdxW-1:0]]];
      end
   end

   // stable descending insert: every entry shifts or holds in parallel
   logic [fad_pkg::CandCntW-1:0] lastpos;
   always_comb lastpos = (count_ff < fad_pkg::CandCntW'(fad_pkg::MaxCand)) ?
                         count_ff : fad_pkg::CandCntW'(fad_pkg::MaxCand - 1);
   always_ff @(posedge clock) begin
      if (do_insert) begin
         for (int p = 0; p < fad_pkg::MaxCand; p++) begin
            if (fad_pkg::CandCntW'(p) <= lastpos) begin
               if (p > 0 && work_ff.box.score > store_ff[(p > 0) ? p-1 : 0].score) begin
                  store_ff[p] <= store_ff[(p > 0) ? p-1 : 0];
               end else if (p == 0 || !(work_ff.box.score >
                            store_ff[(p > 0) ? p-1 : 0].score)) begin
                  if (fad_pkg::CandCntW'(p) == lastpos ||
                      work_ff.box.score > store_ff[p].score)
                     store_ff[p] <= work_ff.box;
               end
            end
         end
      end
   end

   a_kept: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= fad_pkg::FaceCntW'(fad_pkg::MaxFaces))
      else $error("too many kept faces");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fad_pkg::CandCntW'(fad_pkg::MaxCand))
      else $error("candidate count overflow");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == fad_pkg::ST_EMIT |-> kept_ff != '0)
      else $error("emitting with no kept face");

endmodule
`default_nettype wire

[sv/face_anchor_decode_topk_nms.sv]
// channel | dir | handshake          | payload
// req     | in  | req_tvalid/tready  | tdata anchor fields, tlast frame_end
// rsp     | out | rsp_tvalid/tready  | tdata box and score, tuser face_valid, tlast final_face
// csr     | in  | csr_valid/ready    | csr_index, csr_data
// An anchor passes the front pipeline (stage 1 and output registers), the queue and
// the back unit (take and parallel list insert); the back unit sets the pace, taking a
// new item only once it has inserted the last. After the frame's last anchor, suppression
// tests each candidate against each kept face in turn, then sends one beat per face.
// Reset is synchronous and clears counts; the candidate list needs no clearing pass.
// Either side may stall; the queue between front and back absorbs the gap.
`default_nettype none
module face_anchor_decode_topk_nms (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // anchor_index[9:0], score_logit[25:10], offset_x[41:26], offset_y[57:42],
   // width[73:58], box_height[89:74], zero fill
   input  wire logic [95:0]  req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // left[9:0], top[19:10], right[29:20], bottom[39:30], face_score[55:40]
   output logic [55:0]       rsp_tdata,
   // face_valid[0]
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [3:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   logic signed [15:0] logit_thr_ff;
   logic [7:0]         overlap_thr_ff;
   logic [9:0]         screen_w_ff, screen_h_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         logit_thr_ff   <= 16'sd217;
         overlap_thr_ff <= 8'd77;
         screen_w_ff    <= 10'd240;
         screen_h_ff    <= 10'd240;
      end else if (csr_valid) begin
         case (csr_index)
            fad_pkg::CsrLogitThr:   logit_thr_ff   <= csr_data;
            fad_pkg::CsrOverlapThr: overlap_thr_ff <= csr_data[7:0];
            fad_pkg::CsrScreenW:    screen_w_ff    <= csr_data[9:0];
            fad_pkg::CsrScreenH:    screen_h_ff    <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   logic              f_valid, f_ready, q_valid, q_ready;
   fad_pkg::work_type f_work, q_work;
   fad_pkg::box_type  r_box;

   fad_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .anchor_id(req_tdata[9:0]),
      .score_logit(req_tdata[25:10]),
      .offset_x(req_tdata[41:26]),
      .offset_y(req_tdata[57:42]),
      .size_w(req_tdata[73:58]),
      .size_h(req_tdata[89:74]),
      .frame_end(req_tlast),
      .logit_threshold(logit_thr_ff),
      .screen_width(screen_w_ff),
      .screen_height(screen_h_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
   );

   fad_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_work(f_work),
      .out_valid(q_valid), .out_ready(q_ready), .out_work(q_work)
   );

   fad_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_work(q_work),
      .overlap_threshold(overlap_thr_ff),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_face(rsp_tuser), .rsp_box(r_box), .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {r_box.score, r_box.y2, r_box.x2, r_box.y1, r_box.x1};

endmodule
`default_nettype wire

[tb/face_anchor_decode_topk_nms_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module face_anchor_decode_topk_nms_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [95:0]  req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [55:0]  rsp_tdata,
   input  wire logic         rsp_tuser,
   input  wire logic         rsp_tlast,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [3:0]   csr_index,
   input  wire logic [15:0]  csr_data,
   output int                fail_count,
   output int                faces_pending,
   output int                faces_seen,
   output int                frames_seen
);

   // one expected output beat
   typedef struct packed {
      logic       face_valid;
      logic [9:0] left;
      logic [9:0] top;
      logic [9:0] right;
      logic [9:0] bottom;
      logic [15:0] score;
      logic       last;
   } face_type;

   logic signed [15:0] thr_logit;
   logic [7:0]         thr_overlap;
   logic [9:0]         scr_w;
   logic [9:0]         scr_h;
   fad_pkg::box_type   cand_list [fad_pkg::MaxCand];
   int                 cand_num;
   face_type           face_queue [$];

   assign faces_pending = face_queue.size();

   // pixel from edge in 1/65536 screen units, clamped
   function automatic logic [9:0] edge_to_pixel(longint edge_pos, logic [9:0] dim);
      longint v;
      longint p;
      longint lim;
      v = edge_pos * longint'(dim) + 32768;
      lim = (dim == 0) ? 0 : longint'(dim) - 1;
      if (v < 0) return 0;
      p = v >>> 16;
      return (p > lim) ? lim[9:0] : p[9:0];
   endfunction

   function automatic bit boxes_overlap(fad_pkg::box_type a, fad_pkg::box_type b);
      longint ix1, iy1, ix2, iy2, inter, ua;
      ix1 = (a.x1 > b.x1) ? a.x1 : b.x1;
      iy1 = (a.y1 > b.y1) ? a.y1 : b.y1;
      ix2 = (a.x2 < b.x2) ? a.x2 : b.x2;
      iy2 = (a.y2 < b.y2) ? a.y2 : b.y2;
      if (ix2 <= ix1 || iy2 <= iy1) return 0;
      inter = (ix2 - ix1) * (iy2 - iy1);
      ua = longint'(a.x2 - a.x1) * longint'(a.y2 - a.y1)
         + longint'(b.x2 - b.x1) * longint'(b.y2 - b.y1) - inter;
      if (ua <= 0) return 0;
      return inter * 256 > longint'(thr_overlap) * ua;
   endfunction

   // decode one anchor and insert it in the score-ordered list
   task automatic decode_and_insert(logic [95:0] d);
      logic [9:0]         idx;
      logic signed [15:0] sc;
      longint             ox, oy, w, h, ax, ay, unit_sz;
      int                 loc, grid, per, cell_num, pos;
      fad_pkg::box_type   b;
      idx = d[9:0];
      sc  = d[25:10];
      ox  = longint'($signed(d[41:26]));
      oy  = longint'($signed(d[57:42]));
      w   = longint'($signed(d[73:58]));
      h   = longint'($signed(d[89:74]));
      if (sc < thr_logit) return;
      if (idx < 512) begin
         loc = idx; grid = 16; per = 2; unit_sz = 2048;
      end else begin
         loc = idx - 512; grid = 8; per = 6; unit_sz = 4096;
      end
      cell_num = loc / per;
      ax = 2 * ox + longint'(2 * (cell_num % grid) + 1) * unit_sz;
      ay = 2 * oy + longint'(2 * (cell_num / grid) + 1) * unit_sz;
      b.x1 = edge_to_pixel(ax - w, scr_w);
      b.x2 = edge_to_pixel(ax + w, scr_w);
      b.y1 = edge_to_pixel(ay - h, scr_h);
      b.y2 = edge_to_pixel(ay + h, scr_h);
      b.score = sc;
      if (int'(b.x2) - int'(b.x1) < 4 || int'(b.y2) - int'(b.y1) < 4) return;
      pos = cand_num;
      if (pos >= fad_pkg::MaxCand) begin
         if (b.score <= cand_list[fad_pkg::MaxCand-1].score) return;
         pos = fad_pkg::MaxCand - 1;
      end else begin
         cand_num++;
      end
      while (pos > 0 && b.score > cand_list[pos-1].score) begin
         cand_list[pos] = cand_list[pos-1];
         pos--;
      end
      cand_list[pos] = b;
   endtask

   // greedy suppression at frame end, queue the surviving faces
   task automatic suppress_and_queue();
      int       kept [fad_pkg::MaxFaces];
      int       nkept;
      bit       keep;
      face_type f;
      nkept = 0;
      for (int i = 0; i < cand_num && nkept < fad_pkg::MaxFaces; i++) begin
         keep = 1;
         for (int j = 0; j < nkept; j++)
            if (keep && boxes_overlap(cand_list[i], cand_list[kept[j]])) keep = 0;
         if (keep) begin
            kept[nkept] = i;
            nkept++;
         end
      end
      if (nkept == 0) begin
         f = '0;
         f.last = 1;
         face_queue.push_back(f);
      end
      for (int k = 0; k < nkept; k++) begin
         f.face_valid = 1;
         f.left   = cand_list[kept[k]].x1;
         f.top    = cand_list[kept[k]].y1;
         f.right  = cand_list[kept[k]].x2;
         f.bottom = cand_list[kept[k]].y2;
         f.score  = cand_list[kept[k]].score;
         f.last   = (k + 1 == nkept);
         face_queue.push_back(f);
      end
      cand_num = 0;
   endtask

   face_type got;
   face_type want;

   always @(posedge clock) begin
      if (reset) begin
         thr_logit   <= 16'sd217;
         thr_overlap <= 8'd77;
         scr_w       <= 10'd240;
         scr_h       <= 10'd240;
         cand_num    = 0;
         face_queue.delete();
         fail_count  <= 0;
         faces_seen  <= 0;
         frames_seen <= 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fad_pkg::CsrLogitThr:   thr_logit   <= csr_data;
               fad_pkg::CsrOverlapThr: thr_overlap <= csr_data[7:0];
               fad_pkg::CsrScreenW:    scr_w       <= csr_data[9:0];
               fad_pkg::CsrScreenH:    scr_h       <= csr_data[9:0];
               default: ;
            endcase
         end
         // input beat
         if (req_tvalid && req_tready) begin
            decode_and_insert(req_tdata);
            if (req_tlast) suppress_and_queue();
         end
         // output beat compare
         if (rsp_tvalid && rsp_tready) begin
            got.face_valid = rsp_tuser;
            got.left   = rsp_tdata[9:0];
            got.top    = rsp_tdata[19:10];
            got.right  = rsp_tdata[29:20];
            got.bottom = rsp_tdata[39:30];
            got.score  = rsp_tdata[55:40];
            got.last   = rsp_tlast;
            if (got.face_valid) faces_seen <= faces_seen + 1;
            if (got.last) frames_seen <= frames_seen + 1;
            if (face_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected face beat %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = face_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: face mismatch exp %p got %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

[tb/face_anchor_decode_topk_nms_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module face_anchor_decode_topk_nms_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   int          fail_count, faces_pending, faces_seen, frames_seen;
   int          cycle_count = 0;
   bit          hold_off = 0;
   bit          sink_done = 0;

   face_anchor_decode_topk_nms dut (.*);

   face_anchor_decode_topk_nms_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("** face_anchor_decode_topk_nms: FAILED **");
         $finish;
      end
   end

   // random gap length, mostly short
   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   // receiver: random stalls, with one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   task automatic csr_write(logic [3:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_anchor(logic [9:0] idx, logic [15:0] sc, logic [15:0] ox,
                              logic [15:0] oy, logic [15:0] w, logic [15:0] h,
                              logic last, bit gaps);
      int n;
      n = gaps ? gap_len() : 0;
      if ($urandom_range(0, 3) != 0) n = 0;
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'd0, h, w, oy, ox, sc, idx};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (faces_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // a face-like anchor with random content
   task automatic send_face(logic last);
      logic [15:0] w;
      w = 16'($urandom_range(300, 6000));
      send_anchor(10'($urandom_range(0, 895)), 16'($urandom_range(0, 2000) - 200),
                  16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 4000) - 2000),
                  w, w + 16'($urandom_range(0, 800)) - 16'd400, last, 1'b1);
   endtask

   initial begin
      int nf;
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, index ranges, negative size, empty frame
      send_anchor(10'd0, 16'sd300, 16'h0000, 16'h0000, 16'd2000, 16'd2000, 1'b0, 1'b0);
      send_anchor(10'd511, 16'sd400, 16'h7FFF, 16'h8000, 16'd3000, 16'd3000, 1'b0, 1'b0);
      send_anchor(10'd512, 16'sd300, 16'h0000, 16'h0000, 16'd2000, 16'd2000, 1'b0, 1'b0);
      send_anchor(10'd895, 16'h7FFF, 16'h0100, 16'h0100, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
      send_anchor(10'd1023, 16'sd500, 16'h0000, 16'h0000, 16'd4000, 16'd4000, 1'b0, 1'b0);
      send_anchor(10'd100, 16'sd600, 16'h0000, 16'h0000, 16'h8000, 16'd2000, 1'b0, 1'b0);
      send_anchor(10'd100, 16'sd217, 16'h0000, 16'h0000, 16'd2000, 16'd2000, 1'b0, 1'b0);
      send_anchor(10'd100, 16'sd216, 16'h0000, 16'h0000, 16'd2000, 16'd2000, 1'b0, 1'b0);
      send_anchor(10'd100, 16'sd217, 16'h0000, 16'h0000, 16'd2100, 16'd2000, 1'b1, 1'b0);
      send_anchor(10'd5, 16'h8000, 16'h0000, 16'h0000, 16'd2000, 16'd2000, 1'b1, 1'b0);
      // full list: twenty candidates with mixed scores
      for (int i = 0; i < 20; i++)
         send_anchor(10'(i * 40), 16'($urandom_range(220, 260)), 16'd0, 16'd0,
                     16'd1500, 16'd1500, i == 19, 1'b0);
      drain();

      // sweep register settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(fad_pkg::CsrLogitThr, 16'h8000);
               csr_write(fad_pkg::CsrOverlapThr, 16'd0);
               csr_write(fad_pkg::CsrScreenW, 16'd1023);
               csr_write(fad_pkg::CsrScreenH, 16'd1);
            end
            1: begin
               csr_write(fad_pkg::CsrLogitThr, 16'h7FFF);
               csr_write(fad_pkg::CsrOverlapThr, 16'd255);
               csr_write(fad_pkg::CsrScreenW, 16'd0);
               csr_write(fad_pkg::CsrScreenH, 16'd1023);
            end
            2: begin
               csr_write(fad_pkg::CsrLogitThr, 16'd0);
               csr_write(fad_pkg::CsrOverlapThr, 16'd255);
               csr_write(fad_pkg::CsrScreenW, 16'd1023);
               csr_write(fad_pkg::CsrScreenH, 16'd1023);
            end
            default: begin
               csr_write(fad_pkg::CsrLogitThr, 16'($urandom_range(0, 400)));
               csr_write(fad_pkg::CsrOverlapThr, 16'($urandom_range(0, 255)));
               csr_write(fad_pkg::CsrScreenW, 16'($urandom_range(1, 1023)));
               csr_write(fad_pkg::CsrScreenH, 16'($urandom_range(1, 1023)));
            end
         endcase
         for (int f = 0; f < 5; f++) begin
            nf = $urandom_range(1, 12);
            if (phase == 3 && f == 2) hold_off = 1;
            for (int i = 0; i < nf; i++) begin
               if ($urandom_range(0, 5) == 0)
                  send_anchor(10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), i == nf - 1, 1'b1);
               else
                  send_face(i == nf - 1);
            end
         end
         drain();
      end

      $display("covered %0d frames with %0d faces over six register settings",
               frames_seen, faces_seen);
      if (fail_count == 0) begin
         $display("** face_anchor_decode_topk_nms: PASSED **");
      end else begin
         $display("** face_anchor_decode_topk_nms: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
